### hdl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_NUM_SYMBOLS  = 256;
    localparam int CODE_W           = 32;
    localparam int LEN_W            = 6;
    localparam int BYTE_W           = 8;
    localparam int PEND_W           = 7;
    localparam int PCNT_W           = 3;
    localparam int BURST_W          = 3;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              stream_end;
        logic [31:0]       total_bits;
    } t_out_item;

    // Looked-up entry handed from the table stage to the packer.
    typedef struct packed {
        logic              encode;
        logic              finish;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_lookup;

endpackage

`default_nettype wire

### hdl/hcbp_table.sv
// Code table memory and lookup stage register.
`default_nettype none

module hcbp_table #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = hcbp_pkg::DEF_NUM_SYMBOLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  hcbp_pkg::t_in_item i_item,
    output logic               o_lk_valid,
    output hcbp_pkg::t_lookup  o_lk,
    input  logic               i_lk_ready
);
    import hcbp_pkg::*;

    localparam int IDX_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int LEN_BOUND = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [CODE_W-1:0] r_code_mem [NUM_SYMBOLS];
    logic [LEN_W-1:0]  r_len_mem  [NUM_SYMBOLS];

    logic [CODE_W-1:0] r_rd_code;
    logic [LEN_W-1:0]  r_rd_len;
    logic              r_valid;
    logic              r_encode;
    logic              r_finish;
    logic              r_hit;

    logic              accept;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  len_sat;
    logic              fwd;

    assign o_stall = r_valid & ~i_lk_ready;
    assign accept  = i_valid & ~o_stall;
    assign hit     = ({1'b0, i_item.symbol} < 9'(NUM_SYMBOLS));
    assign idx     = i_item.symbol[IDX_W-1:0];
    assign len_sat = (i_item.code_length > LEN_W'(LEN_BOUND)) ? LEN_W'(LEN_BOUND)
                                                              : i_item.code_length;
    assign fwd     = (i_item.mode == MODE_ENCODE) || (i_item.mode == MODE_FINISH);

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.mode == MODE_LOAD) && hit) begin
            r_code_mem[idx] <= i_item.code_word;
            r_len_mem[idx]  <= len_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_code <= r_code_mem[idx];
            r_rd_len  <= r_len_mem[idx];
            r_encode  <= (i_item.mode == MODE_ENCODE);
            r_finish  <= (i_item.mode == MODE_FINISH);
            r_hit     <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= fwd;
        end else if (i_lk_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_lk_valid = r_valid;

    always_comb begin
        o_lk.encode = r_encode;
        o_lk.finish = r_finish;
        o_lk.code   = r_rd_code;
        o_lk.len    = r_hit ? r_rd_len : '0;
    end

endmodule

`default_nettype wire

### hdl/hcbp_packer.sv
// Bit accumulator, byte packer and output burst register.
`default_nettype none

module hcbp_packer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_lk_valid,
    input  hcbp_pkg::t_lookup   i_lk,
    output logic                o_lk_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output hcbp_pkg::t_out_item o_item
);
    import hcbp_pkg::*;

    localparam int ACC_W = CODE_W + PEND_W;
    localparam int AL_W  = ACC_W + 1;

    logic [PEND_W-1:0]   r_pend_bits;
    logic [PCNT_W-1:0]   r_pend_cnt;
    logic [31:0]         r_count;
    logic [CODE_W-1:0]   r_burst;
    logic [BURST_W-1:0]  r_left;
    logic                r_byte_valid;
    logic                r_end;
    logic [31:0]         r_total;

    logic [CODE_W-1:0]   code;
    logic [ACC_W-1:0]    acc;
    logic [LEN_W-1:0]    have;
    logic [AL_W-1:0]     al;
    logic [BURST_W-1:0]  nbytes;
    logic [32:0]         sum;
    logic [31:0]         n_count;
    logic [PCNT_W-1:0]   n_pend_cnt;
    logic [PEND_W-1:0]   n_pend_bits;
    logic [BYTE_W-1:0]   fin_byte;
    logic [BURST_W-1:0]  res_cnt;
    logic                take;
    logic                burst_free;
    logic                consume;
    logic                enc_live;

    always_comb begin
        code = (i_lk.len == '0) ? '0
             : (i_lk.code & ({CODE_W{1'b1}} >> (LEN_W'(CODE_W) - i_lk.len)));
        acc  = (ACC_W'(r_pend_bits) << i_lk.len) | ACC_W'(code);
        have = LEN_W'(r_pend_cnt) + i_lk.len;
        // top-align the accumulated bits so whole bytes sit at the top
        al   = {1'b0, acc} << (LEN_W'(AL_W) - have);
        nbytes      = have[LEN_W-1:PCNT_W];
        n_pend_cnt  = have[PCNT_W-1:0];
        n_pend_bits = acc[PEND_W-1:0] & ({PEND_W{1'b1}} >> (PCNT_W'(PEND_W) - n_pend_cnt));
        sum         = {1'b0, r_count} + 33'(i_lk.len);
        n_count     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        fin_byte    = BYTE_W'({1'b0, r_pend_bits} << (4'd8 - {1'b0, r_pend_cnt}));
        enc_live    = i_lk.encode && (i_lk.len != '0);
    end

    always_comb begin
        if (enc_live) begin
            res_cnt = nbytes;
        end else if (i_lk.finish) begin
            res_cnt = BURST_W'(1);
        end else begin
            res_cnt = '0;
        end
    end

    assign o_valid    = (r_left != '0);
    assign take       = o_valid & ~i_stall;
    assign burst_free = (r_left == '0) || (take && (r_left == BURST_W'(1)));
    assign o_lk_ready = (res_cnt == '0) || burst_free;
    assign consume    = i_lk_valid & o_lk_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_count     <= '0;
        end else if (consume) begin
            if (enc_live) begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
                r_count     <= n_count;
            end else if (i_lk.finish) begin
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
                r_count     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (consume && (res_cnt != '0)) begin
            r_left <= res_cnt;
        end else if (take) begin
            r_left <= r_left - BURST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && (res_cnt != '0)) begin
            r_burst      <= enc_live ? al[AL_W-1 -: CODE_W] : {fin_byte, {(CODE_W-BYTE_W){1'b0}}};
            r_byte_valid <= enc_live ? 1'b1 : (r_pend_cnt != '0);
            r_end        <= ~enc_live;
            r_total      <= enc_live ? n_count : r_count;
        end else if (take) begin
            // advance to the next byte of the burst
            r_burst <= r_burst << BYTE_W;
        end
    end

    always_comb begin
        o_item.out_byte   = r_burst[CODE_W-1 -: BYTE_W];
        o_item.byte_valid = r_byte_valid;
        o_item.stream_end = r_end;
        o_item.total_bits = r_total;
    end

endmodule

`default_nettype wire

### hdl/huffman_code_bit_packer_top.sv
// Huffman encoder back end: code table lookup and bit packer.
//
// Input channel (i_valid/o_stall/i_item) takes one beat per unstalled cycle:
//   mode load writes a symbol's code word and length into the table,
//   mode encode appends that symbol's code, MSB first, to the bit stream,
//   mode finish pads the last partial byte with zeros and closes the stream.
// Output channel (o_valid / i_stall / o_item) carries one byte per beat with
// the earliest bit in bit 7, plus the running saturating bit count.
// The first byte of an item passes the lookup stage register and then the
// output burst register. Throughput: one item per cycle while the receiver
// does not stall and each item yields at most one byte; an encode item that
// completes n bytes (up to four) holds the packer until the output burst
// register has drained all n of them, one byte per beat.
// A finish beat always yields exactly one output beat; on an empty stream it
// carries byte_valid low. Load beats and zero-length codes yield nothing.
// Reset clears pending bits, bit count and all handshake state; the code table
// has no reset value; the user must load every symbol before use, unchecked.
// When the receiver stalls, the output beat holds and back-pressure reaches
// o_stall once the lookup stage is also full.
`default_nettype none

module huffman_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = hcbp_pkg::DEF_NUM_SYMBOLS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hcbp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output hcbp_pkg::t_out_item o_item
);
    import hcbp_pkg::*;

    logic    lk_valid;
    logic    lk_ready;
    t_lookup lk;

    hcbp_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_lk_valid (lk_valid),
        .o_lk       (lk),
        .i_lk_ready (lk_ready)
    );

    hcbp_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lk_valid (lk_valid),
        .i_lk       (lk),
        .o_lk_ready (lk_ready),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

`default_nettype wire
